>>> src/rpl_pkg.sv
package rpl_pkg;

    localparam int PAGE_W       = 8;
    localparam int AGE_W        = 16;
    localparam int SLOT_W       = 3;
    localparam int FIU_W        = 3;
    localparam int OUT_FRAMES   = 7;
    localparam int MAX_FRAMES_DEF = 7;
    localparam int FRAMES_LIMIT = 16;
    localparam int IDX_W        = 4;   // holds any frame index up to FRAMES_LIMIT-1
    localparam int CNT_W        = 5;   // holds a frame count up to FRAMES_LIMIT
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    localparam logic [AGE_W-1:0]  AGE_MAX      = '1;
    localparam logic [AGE_W-1:0]  AGE_RESET    = AGE_W'(1);
    localparam logic [FIU_W-1:0]  FIU_RESET    = FIU_W'(7);
    localparam logic [PAGE_W-1:0] MARKER_RESET = PAGE_W'(10);

    // register index, taken from paddr[2]
    localparam logic REG_FRAMES_IN_USE = 1'b0;
    localparam logic REG_EMPTY_MARKER  = 1'b1;

    typedef struct packed {
        logic [FIU_W-1:0]  frames_in_use;
        logic [PAGE_W-1:0] empty_marker;
    } cfg_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } sel_t;

endpackage

>>> src/rpl_cfg_regs.sv
module rpl_cfg_regs
    import rpl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    logic wr_en;

    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frames_in_use <= FIU_RESET;
            cfg_reg.empty_marker  <= MARKER_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_FRAMES_IN_USE: cfg_reg.frames_in_use <= pwdata[FIU_W-1:0];
                REG_EMPTY_MARKER:  cfg_reg.empty_marker  <= pwdata[PAGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FRAMES_IN_USE: prdata = APB_DATA_W'(cfg_reg.frames_in_use);
            REG_EMPTY_MARKER:  prdata = APB_DATA_W'(cfg_reg.empty_marker);
            default:           prdata = '0;
        endcase
    end

endmodule

>>> src/rpl_select.sv
module rpl_select
    import rpl_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic [PAGE_W-1:0] pages [MAX_FRAMES],
    input  logic [AGE_W-1:0]  ages  [MAX_FRAMES],
    input  logic [MAX_FRAMES-1:0] valid,
    input  logic [MAX_FRAMES-1:0] in_use,
    input  logic [PAGE_W-1:0] page,
    output sel_t              sel
);

    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] oldest;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      old_idx;
    logic                  hit_found;
    logic                  old_found;

    // tag match per frame
    always_comb begin
        for (int k = 0; k < MAX_FRAMES; k++) begin
            match[k] = in_use[k] && valid[k] && (pages[k] == page);
        end
    end

    // frame k wins if strictly older than every lower frame and at least as old
    // as every higher frame, so ties go to the lowest index
    always_comb begin
        for (int k = 0; k < MAX_FRAMES; k++) begin
            oldest[k] = in_use[k];
            for (int j = 0; j < MAX_FRAMES; j++) begin
                if (in_use[j] && (j < k) && !(ages[k] > ages[j])) begin
                    oldest[k] = 1'b0;
                end
                if (in_use[j] && (j > k) && (ages[k] < ages[j])) begin
                    oldest[k] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        hit_idx   = '0;
        old_idx   = '0;
        hit_found = 1'b0;
        old_found = 1'b0;
        for (int k = 0; k < MAX_FRAMES; k++) begin
            if (match[k] && !hit_found) begin
                hit_idx   = IDX_W'(k);
                hit_found = 1'b1;
            end
            if (oldest[k] && !old_found) begin
                old_idx   = IDX_W'(k);
                old_found = 1'b1;
            end
        end
        sel.hit = hit_found;
        sel.idx = hit_found ? hit_idx : old_idx;
    end

endmodule

>>> src/lru_page_frame_replacer.sv
// a request waits in the request register, then moves into the result register
// throughput: one request per cycle unless the result stalls; the hit/victim
// compare tree is combinational; frame state and result register load at one edge
// reset: synchronous, active-low aresetn; frames go empty with marker 10 and age 1,
// frames_in_use returns to 7, empty_marker to 10, both channels come up empty
module lru_page_frame_replacer
    import rpl_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PAGE_W-1:0]     s_page,
    input  logic                  s_start_req,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_fault,
    output logic [SLOT_W-1:0]     m_slot,
    output logic [PAGE_W-1:0]     m_frame_0,
    output logic [PAGE_W-1:0]     m_frame_1,
    output logic [PAGE_W-1:0]     m_frame_2,
    output logic [PAGE_W-1:0]     m_frame_3,
    output logic [PAGE_W-1:0]     m_frame_4,
    output logic [PAGE_W-1:0]     m_frame_5,
    output logic [PAGE_W-1:0]     m_frame_6
);

    cfg_t cfg;

    // request register
    logic              in_valid_reg;
    logic [PAGE_W-1:0] in_page_reg;
    logic              in_start_reg;

    // frame state
    logic [PAGE_W-1:0]     pages_reg [MAX_FRAMES];
    logic [AGE_W-1:0]      ages_reg  [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] valid_reg;

    // state after an optional start, seen by the compare logic
    logic [PAGE_W-1:0]     pages_eff [MAX_FRAMES];
    logic [AGE_W-1:0]      ages_eff  [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] valid_eff;

    logic [PAGE_W-1:0]     pages_next [MAX_FRAMES];
    logic [AGE_W-1:0]      ages_next  [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] valid_next;

    // result register
    logic              out_valid_reg;
    logic              out_fault_reg;
    logic [SLOT_W-1:0] out_slot_reg;

    logic [CNT_W-1:0]      n_active;
    logic [MAX_FRAMES-1:0] in_use;
    logic [PAGE_W-1:0]     frame_out [OUT_FRAMES];
    sel_t                  sel;
    logic                  fire;

    assign pready = 1'b1;

    rpl_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // a held request is processed whenever the result register is free or draining
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_page_reg  <= s_page;
            in_start_reg <= s_start_req;
        end
    end

    // frame count clamped to 1..MAX_FRAMES
    always_comb begin
        if (cfg.frames_in_use == '0) begin
            n_active = CNT_W'(1);
        end else if (CNT_W'(cfg.frames_in_use) > CNT_W'(MAX_FRAMES)) begin
            n_active = CNT_W'(MAX_FRAMES);
        end else begin
            n_active = CNT_W'(cfg.frames_in_use);
        end
        for (int k = 0; k < MAX_FRAMES; k++) begin
            in_use[k] = (CNT_W'(k) < n_active);
        end
    end

    // a start request empties every frame before the lookup
    always_comb begin
        for (int k = 0; k < MAX_FRAMES; k++) begin
            pages_eff[k] = in_start_reg ? cfg.empty_marker : pages_reg[k];
            ages_eff[k]  = in_start_reg ? AGE_RESET : ages_reg[k];
            valid_eff[k] = in_start_reg ? 1'b0 : valid_reg[k];
        end
    end

    rpl_select #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_select (
        .pages  (pages_eff),
        .ages   (ages_eff),
        .valid  (valid_eff),
        .in_use (in_use),
        .page   (in_page_reg),
        .sel    (sel)
    );

    // load the victim on a fault, clear the chosen age, age every frame in use
    always_comb begin
        for (int k = 0; k < MAX_FRAMES; k++) begin
            pages_next[k] = pages_eff[k];
            ages_next[k]  = ages_eff[k];
            valid_next[k] = valid_eff[k];
            if (IDX_W'(k) == sel.idx) begin
                ages_next[k] = '0;
                if (!sel.hit) begin
                    pages_next[k] = in_page_reg;
                    valid_next[k] = 1'b1;
                end
            end
            if (in_use[k] && (ages_next[k] != AGE_MAX)) begin
                ages_next[k] = ages_next[k] + AGE_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int k = 0; k < MAX_FRAMES; k++) begin
                pages_reg[k] <= MARKER_RESET;
                ages_reg[k]  <= AGE_RESET;
            end
        end else if (fire) begin
            valid_reg <= valid_next;
            for (int k = 0; k < MAX_FRAMES; k++) begin
                pages_reg[k] <= pages_next[k];
                ages_reg[k]  <= ages_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_fault_reg <= !sel.hit;
            out_slot_reg  <= sel.idx[SLOT_W-1:0];
        end
    end

    // frame state only moves when a new result is loaded, so it always matches
    // the result currently on offer and drives the frame fields directly
    generate
        for (genvar k = 0; k < OUT_FRAMES; k++) begin : g_frame_out
            if (k < MAX_FRAMES) begin : g_live
                assign frame_out[k] = pages_reg[k];
            end else begin : g_none
                assign frame_out[k] = '0;
            end
        end
    endgenerate

    assign m_valid   = out_valid_reg;
    assign m_fault   = out_fault_reg;
    assign m_slot    = out_slot_reg;
    assign m_frame_0 = frame_out[0];
    assign m_frame_1 = frame_out[1];
    assign m_frame_2 = frame_out[2];
    assign m_frame_3 = frame_out[3];
    assign m_frame_4 = frame_out[4];
    assign m_frame_5 = frame_out[5];
    assign m_frame_6 = frame_out[6];

endmodule

>>> src/rpl_checker.sv
module rpl_checker
    import rpl_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_fault,
    input logic [SLOT_W-1:0] m_slot,
    input logic [PAGE_W-1:0] m_frame_0,
    input logic [PAGE_W-1:0] m_frame_6
);

    // both channels come up empty out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("channels not empty after reset");

    // at most seven frames take part, so the slot never reads seven
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_slot != SLOT_W'(7)))
        else $error("slot out of range");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fault) && $stable(m_slot)
            && $stable(m_frame_0) && $stable(m_frame_6))
        else $error("stalled result changed");

    // the request side never backs up while the result side is empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("request refused with result channel empty");

endmodule

bind lru_page_frame_replacer rpl_checker u_rpl_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_fault   (m_fault),
    .m_slot    (m_slot),
    .m_frame_0 (m_frame_0),
    .m_frame_6 (m_frame_6)
);
